// ----- hw/rtl/rwcp_pkg.sv -----
// Shared types and constants for the RIFF/WAVE chunk parser.
package rwcp_pkg;

    // Tags, compared as big-endian 32-bit words.
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // Format chunk layout.
    localparam logic [31:0] FMT_MIN_SIZE      = 32'd16;
    localparam logic [2:0]  FMT_SKIPPED_BYTES = 3'd6;
    localparam logic [15:0] FMT_CODE_PCM      = 16'd1;

    // Result kinds.
    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes.
    localparam logic ERR_INVALID     = 1'b0;
    localparam logic ERR_UNSUPPORTED = 1'b1;

    // Kind of the chunk being walked.
    typedef enum logic [1:0] {
        CK_OTHER = 2'd0,
        CK_FMT   = 2'd1,
        CK_DATA  = 2'd2
    } t_chunk_kind;

    // Parser phase, one-hot.
    typedef enum logic [12:0] {
        PH_RIFF_TAG   = 13'b0_0000_0000_0001,
        PH_RIFF_SIZE  = 13'b0_0000_0000_0010,
        PH_WAVE_TAG   = 13'b0_0000_0000_0100,
        PH_CHUNK_ID   = 13'b0_0000_0000_1000,
        PH_CHUNK_SIZE = 13'b0_0000_0001_0000,
        PH_FMT_CODE   = 13'b0_0000_0010_0000,
        PH_FMT_CHAN   = 13'b0_0000_0100_0000,
        PH_FMT_RATE   = 13'b0_0000_1000_0000,
        PH_FMT_IGNORE = 13'b0_0001_0000_0000,
        PH_FMT_BITS   = 13'b0_0010_0000_0000,
        PH_SKIP       = 13'b0_0100_0000_0000,
        PH_DATA       = 13'b0_1000_0000_0000,
        PH_HALT       = 13'b1_0000_0000_0000
    } t_phase;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        chunk_last;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] sample_bits;
        logic        err_cause;
    } t_result;

    // Handshake between the parse stage and the result register.
    typedef struct packed {
        logic take;
        logic has_result;
    } t_step_ctl;

endpackage

// ----- hw/rtl/rwcp_if.sv -----
// Request channels of the RIFF/WAVE chunk parser: input bytes and results.
interface rwcp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface rwcp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        chunk_last;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
    logic        err_cause;

    modport source (output valid, output kind, output payload_byte, output chunk_last,
                    output channel_count, output rate_hz, output sample_bits,
                    output err_cause, input ready);
    modport sink (input valid, input kind, input payload_byte, input chunk_last,
                  input channel_count, input rate_hz, input sample_bits,
                  input err_cause, output ready);
endinterface

// ----- hw/rtl/rwcp_parse.sv -----
// Parser state machine: consumes one file byte per step and forms its result.
module rwcp_parse import rwcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_has_result,
    output t_result    o_result
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [31:0] r_shift, n_shift;
    t_chunk_kind r_ckind, n_ckind;
    logic [31:0] r_chunk_rem, n_chunk_rem;
    logic [31:0] r_riff_rem, n_riff_rem;
    logic [15:0] r_channels, n_channels;
    logic [31:0] r_rate, n_rate;

    logic [2:0]  cnt_inc;
    logic [31:0] shift_be;
    logic [31:0] shift_le;
    logic [31:0] chunk_dec;
    t_phase      chunk_end_phase;

    // Field assembly helpers shared by the phases.
    assign cnt_inc   = r_cnt + 3'd1;
    assign shift_be  = {r_shift[23:0], i_byte};
    assign shift_le  = {i_byte, r_shift[31:8]};
    assign chunk_dec = (r_chunk_rem != 32'd0) ? r_chunk_rem - 32'd1 : r_chunk_rem;

    // Next state and result for the byte at the input.
    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_shift      = r_shift;
        n_ckind      = r_ckind;
        n_chunk_rem  = r_chunk_rem;
        n_riff_rem   = r_riff_rem;
        n_channels   = r_channels;
        n_rate       = r_rate;
        o_has_result = 1'b0;
        o_result     = '0;

        // The RIFF body counts down on every chunk byte after the WAVE tag, stopping at zero.
        if (r_phase inside {PH_CHUNK_ID, PH_CHUNK_SIZE, PH_FMT_CODE, PH_FMT_CHAN,
                            PH_FMT_RATE, PH_FMT_IGNORE, PH_FMT_BITS, PH_SKIP, PH_DATA}
            && r_riff_rem != 32'd0) begin
            n_riff_rem = r_riff_rem - 32'd1;
        end
        chunk_end_phase = (n_riff_rem == 32'd0) ? PH_RIFF_TAG : PH_CHUNK_ID;

        unique case (r_phase)
            PH_RIFF_TAG: begin
                n_shift = shift_be;
                n_cnt   = cnt_inc;
                if (cnt_inc == 3'd4) begin
                    n_cnt   = '0;
                    n_shift = '0;
                    if (shift_be != TAG_RIFF) begin
                        n_phase            = PH_HALT;
                        o_has_result       = 1'b1;
                        o_result.kind      = KIND_ERROR;
                        o_result.err_cause = ERR_INVALID;
                    end else begin
                        n_phase = PH_RIFF_SIZE;
                    end
                end
            end
            PH_RIFF_SIZE: begin
                n_shift = shift_le;
                n_cnt   = cnt_inc;
                if (cnt_inc == 3'd4) begin
                    n_riff_rem = (shift_le >= 32'd4) ? shift_le - 32'd4 : 32'd0;
                    n_phase    = PH_WAVE_TAG;
                    n_cnt      = '0;
                    n_shift    = '0;
                end
            end
            PH_WAVE_TAG: begin
                n_shift = shift_be;
                n_cnt   = cnt_inc;
                if (cnt_inc == 3'd4) begin
                    n_cnt   = '0;
                    n_shift = '0;
                    if (shift_be != TAG_WAVE) begin
                        n_phase            = PH_HALT;
                        o_has_result       = 1'b1;
                        o_result.kind      = KIND_ERROR;
                        o_result.err_cause = ERR_UNSUPPORTED;
                    end else begin
                        n_phase = chunk_end_phase;
                    end
                end
            end
            PH_CHUNK_ID: begin
                n_shift = shift_be;
                n_cnt   = cnt_inc;
                if (cnt_inc == 3'd4) begin
                    n_cnt   = '0;
                    n_shift = '0;
                    if (shift_be == TAG_RIFF) begin
                        n_phase            = PH_HALT;
                        o_has_result       = 1'b1;
                        o_result.kind      = KIND_ERROR;
                        o_result.err_cause = ERR_INVALID;
                    end else begin
                        n_ckind = (shift_be == TAG_FMT)  ? CK_FMT :
                                  (shift_be == TAG_DATA) ? CK_DATA : CK_OTHER;
                        n_phase = PH_CHUNK_SIZE;
                    end
                end
            end
            PH_CHUNK_SIZE: begin
                n_shift = shift_le;
                n_cnt   = cnt_inc;
                if (cnt_inc == 3'd4) begin
                    n_cnt   = '0;
                    n_shift = '0;
                    if (r_ckind == CK_FMT) begin
                        if (shift_le < FMT_MIN_SIZE) begin
                            n_phase            = PH_HALT;
                            o_has_result       = 1'b1;
                            o_result.kind      = KIND_ERROR;
                            o_result.err_cause = ERR_INVALID;
                        end else begin
                            n_chunk_rem = shift_le - FMT_MIN_SIZE;
                            n_phase     = PH_FMT_CODE;
                        end
                    end else begin
                        n_chunk_rem = shift_le;
                        if (shift_le == 32'd0) begin
                            n_phase = chunk_end_phase;
                        end else if (r_ckind == CK_DATA) begin
                            n_phase = PH_DATA;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
            end
            PH_FMT_CODE: begin
                n_shift = shift_le;
                n_cnt   = cnt_inc;
                if (cnt_inc == 3'd2) begin
                    n_cnt   = '0;
                    n_shift = '0;
                    if (shift_le[31:16] != FMT_CODE_PCM) begin
                        n_phase            = PH_HALT;
                        o_has_result       = 1'b1;
                        o_result.kind      = KIND_ERROR;
                        o_result.err_cause = ERR_UNSUPPORTED;
                    end else begin
                        n_phase = PH_FMT_CHAN;
                    end
                end
            end
            PH_FMT_CHAN: begin
                n_shift = shift_le;
                n_cnt   = cnt_inc;
                if (cnt_inc == 3'd2) begin
                    n_channels = shift_le[31:16];
                    n_phase    = PH_FMT_RATE;
                    n_cnt      = '0;
                    n_shift    = '0;
                end
            end
            PH_FMT_RATE: begin
                n_shift = shift_le;
                n_cnt   = cnt_inc;
                if (cnt_inc == 3'd4) begin
                    n_rate  = shift_le;
                    n_phase = PH_FMT_IGNORE;
                    n_cnt   = '0;
                    n_shift = '0;
                end
            end
            PH_FMT_IGNORE: begin
                // Byte rate and block align are not kept.
                n_cnt = cnt_inc;
                if (cnt_inc == FMT_SKIPPED_BYTES) begin
                    n_phase = PH_FMT_BITS;
                    n_cnt   = '0;
                    n_shift = '0;
                end
            end
            PH_FMT_BITS: begin
                n_shift = shift_le;
                n_cnt   = cnt_inc;
                if (cnt_inc == 3'd2) begin
                    n_cnt                  = '0;
                    n_shift                = '0;
                    o_has_result           = 1'b1;
                    o_result.kind          = KIND_FORMAT;
                    o_result.channel_count = r_channels;
                    o_result.rate_hz       = r_rate;
                    o_result.sample_bits   = shift_le[31:16];
                    n_phase = (r_chunk_rem != 32'd0) ? PH_SKIP : chunk_end_phase;
                end
            end
            PH_SKIP: begin
                n_chunk_rem = chunk_dec;
                if (chunk_dec == 32'd0) begin
                    n_phase = chunk_end_phase;
                    n_cnt   = '0;
                    n_shift = '0;
                end
            end
            PH_DATA: begin
                o_has_result          = 1'b1;
                o_result.kind         = KIND_DATA;
                o_result.payload_byte = i_byte;
                o_result.chunk_last   = (r_chunk_rem <= 32'd1);
                n_chunk_rem           = chunk_dec;
                if (chunk_dec == 32'd0) begin
                    n_phase = chunk_end_phase;
                    n_cnt   = '0;
                    n_shift = '0;
                end
            end
            default: begin
                // Halted after an error: bytes are consumed silently.
                n_phase = r_phase;
            end
        endcase
    end

    // State registers advance only when a byte is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RIFF_TAG;
            r_cnt       <= '0;
            r_shift     <= '0;
            r_ckind     <= CK_OTHER;
            r_chunk_rem <= '0;
            r_riff_rem  <= '0;
            r_channels  <= '0;
            r_rate      <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_shift     <= n_shift;
            r_ckind     <= n_ckind;
            r_chunk_rem <= n_chunk_rem;
            r_riff_rem  <= n_riff_rem;
            r_channels  <= n_channels;
            r_rate      <= n_rate;
        end
    end

endmodule

// ----- hw/rtl/rwcp_out_reg.sv -----
// Result register that drives the output channel.
module rwcp_out_reg import rwcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_step_ctl  i_ctl,
    input  t_result    i_result,
    output logic       o_free,
    rwcp_res_if.source o_out
);

    logic    r_valid;
    t_result r_result;

    // The slot can be refilled when empty or when its request leaves now.
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.take) begin
            r_valid <= i_ctl.has_result;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload is loaded only with a fresh result.
    always_ff @(posedge i_clk) begin
        if (i_ctl.take && i_ctl.has_result) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.kind          = r_result.kind;
    assign o_out.payload_byte  = r_result.payload_byte;
    assign o_out.chunk_last    = r_result.chunk_last;
    assign o_out.channel_count = r_result.channel_count;
    assign o_out.rate_hz       = r_result.rate_hz;
    assign o_out.sample_bits   = r_result.sample_bits;
    assign o_out.err_cause     = r_result.err_cause;

endmodule

// ----- hw/rtl/riff_wave_chunk_parser_core.sv -----
// RIFF/WAVE chunk parser: byte in, at most one result out; one byte per cycle unless held.
//
// The core takes a RIFF/WAVE file one byte per request and sustains one byte per clock
// cycle while the output register is free: each byte passes an input register, is parsed
// combinationally by the state machine, and its result (if any) is loaded into the output
// register when the byte is parsed, from where it can be taken.
// It checks the RIFF and WAVE tags, walks chunks,
// reports the PCM format of the fmt chunk as one format result, passes data chunk bytes
// through with the last one flagged, and skips other chunks. When the RIFF body is used
// up at a chunk boundary it expects a new RIFF tag. Any error is reported once and the
// core then swallows all further bytes without results until reset. Input is only held
// off while the output register holds a result that is not taken.
module riff_wave_chunk_parser_core import rwcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rwcp_byte_if.sink  i_in,
    rwcp_res_if.source o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_free;
    logic       step;
    logic       has_result;
    t_result    result;
    t_step_ctl  ctl;

    // Input register: refilled when empty or when its byte is parsed now.
    assign step       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    // Parse stage.
    rwcp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .o_has_result (has_result),
        .o_result     (result)
    );

    assign ctl.take       = step;
    assign ctl.has_result = has_result;

    // Result register.
    rwcp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule
